FILE: sv/lpiuv_pkg.sv
// ----------------------------------------------------------------------------
// lpiuv_pkg: shared types and constants
// Field formats, internal widths, register codes and the fixed latency of the
// line/plane intersection pipeline.
// ----------------------------------------------------------------------------
package lpiuv_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int AXIS_FRAC_BITS  = 19;
  localparam int NRM_DROP        = 19;

  localparam int COORD_W    = 32;
  localparam int AXIS_W     = 21;
  localparam int AXIS_REG_W = 3 * AXIS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // internal widths
  localparam int XPROD_W = 2 * AXIS_W + 1;          // cross product term
  localparam int NRM_W   = 24;                      // rounded normal component
  localparam int DIFF_W  = COORD_W + 1;             // o - p
  localparam int DEN_W   = 58;                      // den, num
  localparam int MAG_W   = DEN_W;                   // |den|, |num|
  localparam int DIVD_W  = MAG_W + COORD_W;         // |num| * |d|
  localparam int QUO_W   = 42;                      // quotient bits kept
  localparam int HIT_W   = QUO_W + 1;               // clipped hit, signed
  localparam int PROJ_W  = HIT_W + AXIS_W + 2;      // projection sum

  localparam int DIV_STEPS = QUO_W;
  localparam int LATENCY   = 12 + DIV_STEPS;

  localparam int PAR_EXP = COORD_FRAC_BITS + 2 * AXIS_FRAC_BITS - NRM_DROP;
  localparam longint unsigned PAR_RAW =
    ((64'd1 << PAR_EXP) + 64'd500000) / 64'd1000000;
  localparam logic [MAG_W-1:0] PAR_LIMIT =
    (PAR_RAW == 64'd0) ? MAG_W'(1) : MAG_W'(PAR_RAW);

  localparam logic [QUO_W-1:0] HIT_CAP = QUO_W'(1) << (QUO_W - 1);
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

  localparam logic [AXIS_REG_W-1:0] U_AXIS_RST = 63'd524288;
  localparam logic [AXIS_REG_W-1:0] V_AXIS_RST = 63'd1099511627776;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_U_AXIS,
    REG_V_AXIS
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } lpiuv_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
    logic                      parallel;
    logic                      saturated;
  } lpiuv_res_t;

endpackage

FILE: sv/line_plane_intersect_uv_top.sv
// ----------------------------------------------------------------------------
// line_plane_intersect_uv_top: line / plane intersection in plane coordinates
// Takes one line request per cycle and returns its hit point projected onto
// the plane's u and v axes via stages A to G, the divider, then R, H, I, J, K.
// The rate is one request per clock: every step, including the 42-stage
// restoring divider (one quotient bit per stage, three lanes), is fully
// pipelined, so busy_o never rises. Results appear for one cycle with
// valid_o and cannot be held off. Configuration writes are always ready and
// must only happen while no request is in flight.
// ----------------------------------------------------------------------------
module line_plane_intersect_uv_top
  import lpiuv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  lpiuv_req_t            req_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  valid_o,
  output lpiuv_res_t            res_o
);

  typedef struct packed {
    logic                          par;
    logic [MAG_W-1:0]              dmag;
    logic [2:0]                    neg;
    logic [2:0]                    ovf;
    logic [2:0][DIFF_W-1:0]        diff;
  } side_t;

  // configuration
  logic signed [COORD_W-1:0] org_q [3];
  logic [AXIS_REG_W-1:0]     uax_q, vax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      uax_q    <= U_AXIS_RST;
      vax_q    <= V_AXIS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_X: org_q[0] <= cfg_data_i[COORD_W-1:0];
        REG_ORIGIN_Y: org_q[1] <= cfg_data_i[COORD_W-1:0];
        REG_ORIGIN_Z: org_q[2] <= cfg_data_i[COORD_W-1:0];
        REG_U_AXIS:   uax_q    <= cfg_data_i[AXIS_REG_W-1:0];
        REG_V_AXIS:   vax_q    <= cfg_data_i[AXIS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic signed [AXIS_W-1:0]  ua [3];
  logic signed [AXIS_W-1:0]  va [3];
  logic signed [XPROD_W-1:0] cr [3];
  logic signed [XPROD_W-1:0] cr_rnd [3];
  logic signed [NRM_W-1:0]   nrm_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ua[l] = uax_q[AXIS_W*l +: AXIS_W];
      va[l] = vax_q[AXIS_W*l +: AXIS_W];
    end
    cr[0] = ua[1] * va[2] - ua[2] * va[1];
    cr[1] = ua[2] * va[0] - ua[0] * va[2];
    cr[2] = ua[0] * va[1] - ua[1] * va[0];
    for (int l = 0; l < 3; l++) begin
      cr_rnd[l] = (cr[l] + (XPROD_W'(1) <<< (NRM_DROP - 1))) >>> NRM_DROP;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      nrm_q[l] <= cr_rnd[l][NRM_W-1:0];
    end
  end

  // valid shift line
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i & ~busy_o};
    end
  end

  // A: capture request
  logic signed [COORD_W-1:0] a_p_q [3];
  logic signed [COORD_W-1:0] a_d_q [3];

  always_ff @(posedge clk_i) begin
    a_p_q[0] <= req_i.pos_x;
    a_p_q[1] <= req_i.pos_y;
    a_p_q[2] <= req_i.pos_z;
    a_d_q[0] <= req_i.dir_x;
    a_d_q[1] <= req_i.dir_y;
    a_d_q[2] <= req_i.dir_z;
  end

  // B: d*n terms, o-p
  logic signed [COORD_W+NRM_W-1:0] b_dn_q [3];
  logic signed [DIFF_W-1:0]        b_diff_q [3];
  logic signed [COORD_W-1:0]       b_d_q [3];

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      b_dn_q[l]   <= a_d_q[l] * nrm_q[l];
      b_diff_q[l] <= DIFF_W'(org_q[l]) - DIFF_W'(a_p_q[l]);
      b_d_q[l]    <= a_d_q[l];
    end
  end

  // C: den sum, (o-p)*n terms
  logic signed [DEN_W-1:0]        c_den_q;
  logic signed [DIFF_W+NRM_W-1:0] c_np_q [3];
  logic signed [DIFF_W-1:0]       c_diff_q [3];
  logic signed [COORD_W-1:0]      c_d_q [3];

  always_ff @(posedge clk_i) begin
    c_den_q <= DEN_W'(b_dn_q[0]) + DEN_W'(b_dn_q[1]) + DEN_W'(b_dn_q[2]);
    for (int l = 0; l < 3; l++) begin
      c_np_q[l]   <= b_diff_q[l] * nrm_q[l];
      c_diff_q[l] <= b_diff_q[l];
      c_d_q[l]    <= b_d_q[l];
    end
  end

  // D: num sum, |den|, parallel test
  logic signed [DEN_W-1:0]   d_num_q;
  logic [MAG_W-1:0]          d_dmag_q;
  logic                      d_dneg_q;
  logic                      d_par_q;
  logic signed [DIFF_W-1:0]  d_diff_q [3];
  logic signed [COORD_W-1:0] d_d_q [3];
  logic [MAG_W-1:0]          den_mag;

  assign den_mag = c_den_q[DEN_W-1] ? MAG_W'(-c_den_q) : MAG_W'(c_den_q);

  always_ff @(posedge clk_i) begin
    d_num_q  <= DEN_W'(c_np_q[0]) + DEN_W'(c_np_q[1]) + DEN_W'(c_np_q[2]);
    d_dmag_q <= den_mag;
    d_dneg_q <= c_den_q[DEN_W-1];
    d_par_q  <= den_mag < PAR_LIMIT;
    for (int l = 0; l < 3; l++) begin
      d_diff_q[l] <= c_diff_q[l];
      d_d_q[l]    <= c_d_q[l];
    end
  end

  // E: |num| * |d| as two partial products
  logic [MAG_W-1:0]                 num_mag;
  logic [COORD_W-1:0]               dir_mag [3];
  logic [2*COORD_W-1:0]             e_pl_q [3];
  logic [MAG_W-COORD_W+COORD_W-1:0] e_ph_q [3];
  side_t                            e_s_q;

  assign num_mag = d_num_q[DEN_W-1] ? MAG_W'(-d_num_q) : MAG_W'(d_num_q);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dir_mag[l] = d_d_q[l][COORD_W-1] ? COORD_W'(-d_d_q[l]) : COORD_W'(d_d_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    e_s_q.par  <= d_par_q;
    e_s_q.dmag <= d_dmag_q;
    e_s_q.ovf  <= '0;
    for (int l = 0; l < 3; l++) begin
      e_pl_q[l]      <= num_mag[COORD_W-1:0] * dir_mag[l];
      e_ph_q[l]      <= num_mag[MAG_W-1:COORD_W] * dir_mag[l];
      e_s_q.neg[l]   <= d_num_q[DEN_W-1] ^ d_d_q[l][COORD_W-1] ^ d_dneg_q;
      e_s_q.diff[l]  <= d_diff_q[l];
    end
  end

  // F: dividend
  logic [DIVD_W-1:0] f_x_q [3];
  side_t             f_s_q;

  always_ff @(posedge clk_i) begin
    f_s_q <= e_s_q;
    for (int l = 0; l < 3; l++) begin
      f_x_q[l] <= (DIVD_W'(e_ph_q[l]) << COORD_W) + DIVD_W'(e_pl_q[l]);
    end
  end

  // G: divider entry, one quotient bit per stage after it
  logic [MAG_W-1:0] dv_r_q [DIV_STEPS+1][3];
  logic [QUO_W-1:0] dv_w_q [DIV_STEPS+1][3];
  side_t            dv_s_q [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    dv_s_q[0].par  <= f_s_q.par;
    dv_s_q[0].dmag <= f_s_q.dmag;
    dv_s_q[0].neg  <= f_s_q.neg;
    dv_s_q[0].diff <= f_s_q.diff;
    for (int l = 0; l < 3; l++) begin
      dv_r_q[0][l]     <= MAG_W'(f_x_q[l][DIVD_W-1:QUO_W]);
      dv_w_q[0][l]     <= f_x_q[l][QUO_W-1:0];
      dv_s_q[0].ovf[l] <= MAG_W'(f_x_q[l][DIVD_W-1:QUO_W]) >= f_s_q.dmag;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [MAG_W:0]   trial [3];
    logic [2:0]       ge;
    logic [MAG_W-1:0] r_d [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {dv_r_q[k-1][l], dv_w_q[k-1][l][QUO_W-1]};
        ge[l]    = trial[l] >= {1'b0, dv_s_q[k-1].dmag};
        r_d[l]   = ge[l] ? MAG_W'(trial[l] - {1'b0, dv_s_q[k-1].dmag})
                         : trial[l][MAG_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_s_q[k] <= dv_s_q[k-1];
      for (int l = 0; l < 3; l++) begin
        dv_r_q[k][l] <= r_d[l];
        dv_w_q[k][l] <= {dv_w_q[k-1][l][QUO_W-2:0], ge[l]};
      end
    end
  end

  // R: round to nearest, cap, apply sign
  logic [QUO_W:0]           q_rnd [3];
  logic [2:0]               q_sat;
  logic [QUO_W-1:0]         q_mag [3];
  logic signed [HIT_W-1:0]  r_del_q [3];
  logic                     r_sat_q;
  logic                     r_par_q;
  logic signed [DIFF_W-1:0] r_diff_q [3];
  side_t                    dvo;

  assign dvo = dv_s_q[DIV_STEPS];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q_rnd[l] = {1'b0, dv_w_q[DIV_STEPS][l]}
               + (QUO_W+1)'(dv_r_q[DIV_STEPS][l] >= (dvo.dmag - dv_r_q[DIV_STEPS][l]));
      q_sat[l] = dvo.ovf[l] | (q_rnd[l] > {1'b0, HIT_CAP});
      q_mag[l] = q_sat[l] ? HIT_CAP : q_rnd[l][QUO_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r_sat_q <= |q_sat;
    r_par_q <= dvo.par;
    for (int l = 0; l < 3; l++) begin
      r_del_q[l]  <= dvo.neg[l] ? -$signed({1'b0, q_mag[l]}) : $signed({1'b0, q_mag[l]});
      r_diff_q[l] <= dvo.diff[l];
    end
  end

  // H: hit = p - o + offset, clipped
  localparam logic signed [HIT_W:0] H_HI = (HIT_W+1)'(1) <<< (QUO_W - 1);
  localparam logic signed [HIT_W:0] H_LO = -H_HI;

  logic signed [HIT_W:0]   hit [3];
  logic [2:0]              hit_clip;
  logic signed [HIT_W-1:0] h_q [3];
  logic                    h_sat_q;
  logic                    h_par_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      hit[l]      = (HIT_W+1)'(r_del_q[l]) - (HIT_W+1)'(r_diff_q[l]);
      hit_clip[l] = (hit[l] > H_HI) | (hit[l] < H_LO);
    end
  end

  always_ff @(posedge clk_i) begin
    h_sat_q <= r_sat_q | (|hit_clip);
    h_par_q <= r_par_q;
    for (int l = 0; l < 3; l++) begin
      if (hit[l] > H_HI) begin
        h_q[l] <= H_HI[HIT_W-1:0];
      end else if (hit[l] < H_LO) begin
        h_q[l] <= H_LO[HIT_W-1:0];
      end else begin
        h_q[l] <= hit[l][HIT_W-1:0];
      end
    end
  end

  // I: projection terms
  logic signed [HIT_W+AXIS_W-1:0] i_mu_q [3];
  logic signed [HIT_W+AXIS_W-1:0] i_mv_q [3];
  logic                           i_sat_q;
  logic                           i_par_q;

  always_ff @(posedge clk_i) begin
    i_sat_q <= h_sat_q;
    i_par_q <= h_par_q;
    for (int l = 0; l < 3; l++) begin
      i_mu_q[l] <= h_q[l] * ua[l];
      i_mv_q[l] <= h_q[l] * va[l];
    end
  end

  // J: sum and round
  localparam logic signed [PROJ_W-1:0] P_HALF = PROJ_W'(1) <<< (AXIS_FRAC_BITS - 1);

  logic signed [PROJ_W-1:0] j_u_q, j_v_q;
  logic                     j_sat_q;
  logic                     j_par_q;

  always_ff @(posedge clk_i) begin
    j_sat_q <= i_sat_q;
    j_par_q <= i_par_q;
    j_u_q   <= (PROJ_W'(i_mu_q[0]) + PROJ_W'(i_mu_q[1]) + PROJ_W'(i_mu_q[2]) + P_HALF)
               >>> AXIS_FRAC_BITS;
    j_v_q   <= (PROJ_W'(i_mv_q[0]) + PROJ_W'(i_mv_q[1]) + PROJ_W'(i_mv_q[2]) + P_HALF)
               >>> AXIS_FRAC_BITS;
  end

  // K: clamp, output register
  localparam logic signed [PROJ_W-1:0] C_HI = PROJ_W'(COORD_MAX);
  localparam logic signed [PROJ_W-1:0] C_LO = -C_HI - PROJ_W'(1);

  logic                      u_clip, v_clip;
  logic signed [COORD_W-1:0] u_c, v_c;
  lpiuv_res_t                res_q;

  always_comb begin
    u_clip = (j_u_q > C_HI) | (j_u_q < C_LO);
    v_clip = (j_v_q > C_HI) | (j_v_q < C_LO);
    u_c    = (j_u_q > C_HI) ? C_HI[COORD_W-1:0]
           : (j_u_q < C_LO) ? C_LO[COORD_W-1:0] : j_u_q[COORD_W-1:0];
    v_c    = (j_v_q > C_HI) ? C_HI[COORD_W-1:0]
           : (j_v_q < C_LO) ? C_LO[COORD_W-1:0] : j_v_q[COORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (j_par_q) begin
      res_q.u_coord   <= COORD_MAX;
      res_q.v_coord   <= COORD_MAX;
      res_q.parallel  <= 1'b1;
      res_q.saturated <= 1'b0;
    end else begin
      res_q.u_coord   <= u_c;
      res_q.v_coord   <= v_c;
      res_q.parallel  <= 1'b0;
      res_q.saturated <= j_sat_q | u_clip | v_clip;
    end
  end

  assign res_o   = res_q;
  assign valid_o = vld_q[LATENCY-1];

endmodule

FILE: sv/lpiuv_chk.sv
// ----------------------------------------------------------------------------
// lpiuv_chk: port-level checks for line_plane_intersect_uv_top
// Fixed latency, parallel result encoding, cfg ready, never-busy request side.
// ----------------------------------------------------------------------------
module lpiuv_chk
  import lpiuv_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  cfg_ready_o,
  input logic                  valid_o,
  input lpiuv_res_t            res_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("request side held off");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without request at fixed latency");

  a_parallel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.parallel |->
      res_o.u_coord == COORD_MAX && res_o.v_coord == COORD_MAX && !res_o.saturated)
    else $error("parallel result not encoded as maximum");

endmodule

bind line_plane_intersect_uv_top lpiuv_chk u_chk (.*);

FILE: dv/line_plane_intersect_uv_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_plane_intersect_uv_top_test: self-checking bench for the line/plane
// intersection block
// Lines are queued by the stimulus process and issued by a clocked driver with
// random gaps. Each request taken is run through a local fixed-point model of
// the hit point projection, and the monitor compares every result strobe with
// the oldest prediction. The plane registers are rewritten between phases,
// once the pipeline has drained, covering reset, unit, random and extreme
// settings as well as writes to unused register indexes.
// ----------------------------------------------------------------------------
module line_plane_intersect_uv_top_test;
  import lpiuv_pkg::*;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;
  localparam longint PAR_MIN_DEN =
    longint'(((64'd1 << 35) + 64'd500000) / 64'd1000000);
  localparam longint HIT_LIM = longint'(1) << 41;
  localparam logic [AXIS_W-1:0] AX_ONE = 21'h08_0000;
  localparam logic [AXIS_W-1:0] AX_NEG_ONE = 21'h18_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  lpiuv_req_t req_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic valid_o;
  lpiuv_res_t res_o;

  line_plane_intersect_uv_top uut (.*);

  always #6 clk_i = ~clk_i;

  // plane as seen by the model
  logic signed [COORD_W-1:0] org [3];
  logic [AXIS_REG_W-1:0] u_ax, v_ax;

  lpiuv_req_t line_q[$];
  lpiuv_res_t hit_exp_q[$];
  int gap_cnt = 0;
  bit no_gaps = 0;
  int errors = 0, n_hits = 0, n_par = 0, n_sat = 0;

  function automatic longint ax_field(logic [AXIS_REG_W-1:0] a, int i);
    logic signed [AXIS_W-1:0] f;
    f = a[i*AXIS_W +: AXIS_W];
    return longint'(f);
  endfunction

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi, ref bit sat);
    if (x < lo) begin
      sat = 1;
      return lo;
    end
    if (x > hi) begin
      sat = 1;
      return hi;
    end
    return x;
  endfunction

  function automatic lpiuv_res_t predict_hit(lpiuv_req_t r);
    longint p[3], d[3], o[3], ua[3], va[3], n[3], h[3];
    longint den, num, dlt, uc, vc;
    logic [127:0] prod, dm, q, rem;
    bit sat, neg;
    lpiuv_res_t res;
    sat = 0;
    p[0] = r.pos_x; p[1] = r.pos_y; p[2] = r.pos_z;
    d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
    for (int i = 0; i < 3; i++) begin
      o[i] = org[i];
      ua[i] = ax_field(u_ax, i);
      va[i] = ax_field(v_ax, i);
    end
    n[0] = rnd_shift(ua[1] * va[2] - ua[2] * va[1], NRM_DROP);
    n[1] = rnd_shift(ua[2] * va[0] - ua[0] * va[2], NRM_DROP);
    n[2] = rnd_shift(ua[0] * va[1] - ua[1] * va[0], NRM_DROP);
    den = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    if (mag(den) < PAR_MIN_DEN) begin
      res.u_coord = C_MAX;
      res.v_coord = C_MAX;
      res.parallel = 1'b1;
      res.saturated = 1'b0;
      return res;
    end
    num = (o[0] - p[0]) * n[0] + (o[1] - p[1]) * n[1] + (o[2] - p[2]) * n[2];
    dm = 128'(mag(den));
    for (int i = 0; i < 3; i++) begin
      neg = ((num < 0) ^ (d[i] < 0)) ^ (den < 0);
      prod = 128'(mag(num)) * 128'(mag(d[i]));
      q = prod / dm;
      rem = prod % dm;
      if (q > 128'(HIT_LIM)) begin
        sat = 1;
        q = 128'(HIT_LIM);
      end else begin
        if (rem >= dm - rem) q = q + 1;
        if (q > 128'(HIT_LIM)) begin
          sat = 1;
          q = 128'(HIT_LIM);
        end
      end
      dlt = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
      h[i] = clip(p[i] - o[i] + dlt, -HIT_LIM, HIT_LIM, sat);
    end
    uc = rnd_shift(h[0] * ua[0] + h[1] * ua[1] + h[2] * ua[2], AXIS_FRAC_BITS);
    vc = rnd_shift(h[0] * va[0] + h[1] * va[1] + h[2] * va[2], AXIS_FRAC_BITS);
    uc = clip(uc, longint'(C_MIN), longint'(C_MAX), sat);
    vc = clip(vc, longint'(C_MIN), longint'(C_MAX), sat);
    res.u_coord = uc[31:0];
    res.v_coord = vc[31:0];
    res.parallel = 1'b0;
    res.saturated = sat;
    return res;
  endfunction

  function automatic int pick_gap();
    int k;
    if (no_gaps) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (start_i && !busy_o) hit_exp_q.push_back(predict_hit(req_i));
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start_i <= 1'b0;
      end else if (line_q.size() > 0) begin
        req_i <= line_q.pop_front();
        start_i <= 1'b1;
        gap_cnt <= pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (hit_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result u=%h v=%h par=%b sat=%b", $time,
                 res_o.u_coord, res_o.v_coord, res_o.parallel, res_o.saturated);
      end else begin
        lpiuv_res_t e;
        e = hit_exp_q.pop_front();
        n_hits++;
        if (e.parallel) n_par++;
        if (e.saturated) n_sat++;
        if (res_o.u_coord !== e.u_coord) begin
          errors++;
          $display("%0t: u_coord expected %h actual %h", $time, e.u_coord, res_o.u_coord);
        end
        if (res_o.v_coord !== e.v_coord) begin
          errors++;
          $display("%0t: v_coord expected %h actual %h", $time, e.v_coord, res_o.v_coord);
        end
        if (res_o.parallel !== e.parallel) begin
          errors++;
          $display("%0t: parallel expected %b actual %b", $time, e.parallel, res_o.parallel);
        end
        if (res_o.saturated !== e.saturated) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                   res_o.saturated);
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                           int last);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_ORIGIN_X || idx == REG_ORIGIN_Y || idx == REG_ORIGIN_Z)
      org[idx[1:0]] = data[COORD_W-1:0];
    else if (idx == REG_U_AXIS)
      u_ax = data[AXIS_REG_W-1:0];
    else if (idx == REG_V_AXIS)
      v_ax = data[AXIS_REG_W-1:0];
    if (last != 0) cfg_valid_i <= 1'b0;
  endtask

  task automatic push_line(int px, int py, int pz, int dx, int dy, int dz);
    lpiuv_req_t r;
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    line_q.push_back(r);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (line_q.size() > 0 || start_i || hit_exp_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [AXIS_REG_W-1:0] make_axis(int kind);
    logic [AXIS_W-1:0] f [3];
    case (kind)
      0: begin
        for (int i = 0; i < 3; i++) f[i] = '0;
        f[2'($urandom_range(0, 2))] = $urandom_range(0, 1) ? AX_ONE : AX_NEG_ONE;
      end
      1: for (int i = 0; i < 3; i++) f[i] = 21'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: for (int i = 0; i < 3; i++) f[i] = 21'($urandom);
      default: for (int i = 0; i < 3; i++)
        case ($urandom_range(0, 3))
          0: f[i] = 21'h0F_FFFF;
          1: f[i] = 21'h10_0000;
          2: f[i] = 21'h1F_FFFF;
          default: f[i] = '0;
        endcase
    endcase
    return {f[2], f[1], f[0]};
  endfunction

  function automatic int rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
      default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  task automatic random_lines(int cnt);
    int k;
    for (int j = 0; j < cnt; j++) begin
      k = $urandom_range(0, 9);
      if (k < 2)
        push_line($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (k == 2)
        push_line(rand_coord(2), rand_coord(1), rand_coord(2),
                  rand_coord(1), rand_coord(2), rand_coord(3));
      else
        push_line(rand_coord(1), rand_coord(1), rand_coord(1),
                  rand_coord(3), rand_coord(3), rand_coord(3));
    end
  endtask

  initial begin
    org[0] = '0; org[1] = '0; org[2] = '0;
    u_ax = U_AXIS_RST;
    v_ax = V_AXIS_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset plane: z = 0, u = x, v = y
    push_line(0, 0, ONE, 0, 0, 0);                    // zero direction
    push_line(0, 0, ONE, ONE, C_MAX, 0);              // lies in a parallel plane
    push_line(0, 0, ONE, 0, 0, 1);                    // one lsb of z direction, over the limit
    push_line(0, 0, ONE, 0, 0, 2);                    // two lsbs, also over it
    push_line(3 * ONE, -5 * ONE, 7 * ONE, ONE, ONE, -ONE);
    push_line(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    push_line(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    push_line(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
    push_line(0, 0, C_MAX, C_MAX, C_MIN, 2);          // huge offset
    push_line(0, 0, C_MIN, C_MIN, C_MAX, -2);
    push_line(C_MAX, C_MAX, ONE, ONE, ONE, -ONE);     // coordinate overflow
    push_line(C_MIN, 0, -ONE, -ONE, 0, -ONE);
    push_line(-1, -1, -1, -1, -1, -1);
    push_line(0, 0, 0, 0, 0, ONE);                    // starts on the plane
    push_line(12345, -6789, 54321, 0, 0, C_MIN);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      no_gaps = (ph == 3 || ph == 7);
      case (ph)
        0: begin
          cfg_write(REG_ORIGIN_X, 64'(ONE), 0);
          cfg_write(REG_ORIGIN_Y, 64'(-ONE), 0);
          cfg_write(REG_ORIGIN_Z, 64'(2 * ONE), 0);
          cfg_write(REG_U_AXIS, 64'(make_axis(0)), 0);
          cfg_write(REG_V_AXIS, 64'(make_axis(0)), 1);
        end
        1: begin
          cfg_write(REG_ORIGIN_X, 64'(C_MAX), 0);
          cfg_write(REG_ORIGIN_Y, 64'(C_MIN), 0);
          cfg_write(REG_ORIGIN_Z, 64'(C_MAX), 0);
          cfg_write(REG_U_AXIS, 64'(make_axis(3)), 0);
          cfg_write(REG_V_AXIS, 64'(make_axis(3)), 1);
        end
        2: begin
          cfg_write(REG_ORIGIN_X, {$urandom, $urandom}, 0);
          cfg_write(REG_U_AXIS, {$urandom, $urandom}, 0);
          cfg_write(REG_V_AXIS, {$urandom, $urandom}, 0);
          cfg_write(IDX_UNUSED_LO, {$urandom, $urandom}, 0);
          cfg_write(IDX_UNUSED_HI, '1, 1);
        end
        3: begin
          cfg_write(REG_ORIGIN_X, '0, 0);
          cfg_write(REG_ORIGIN_Y, '0, 0);
          cfg_write(REG_ORIGIN_Z, '0, 0);
          cfg_write(REG_U_AXIS, '1, 0);
          cfg_write(REG_V_AXIS, 64'({AX_ONE, AX_NEG_ONE, 21'h0}), 1);
        end
        default: begin
          cfg_write(REG_ORIGIN_X, 64'(rand_coord(ph % 2 ? 1 : 0)), 0);
          cfg_write(REG_ORIGIN_Y, 64'(rand_coord(1)), 0);
          cfg_write(REG_ORIGIN_Z, 64'(rand_coord(3)), 0);
          cfg_write(REG_U_AXIS, 64'(make_axis(ph % 4)), 0);
          cfg_write(REG_V_AXIS, 64'(make_axis((ph + 1) % 3)), 1);
        end
      endcase
      random_lines(215);
      drain();
    end

    $display("Checked %0d results over 10 plane settings: %0d parallel, %0d saturated.",
             n_hits, n_par, n_sat);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
